// ----- sv/dba_pkg.sv -----
package dba_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned MoneyW = 64;
  localparam int unsigned VsumW  = 40;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DaySteps = 4;
  localparam logic [VsumW-1:0] MsPerDay = 40'd86400000;
  // Ceiling of 2^55 / 84375; the day number is ((t >> 10) * DayRecip) >> 55.
  localparam logic [38:0] DayRecip = 39'd427007964670;

  localparam logic CfgBarSize = 1'b0;
  localparam logic CfgMpp     = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DDIV, S_PREP, S_MLO, S_MHI, S_INC, S_ACC, S_CHK, S_ADIV, S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic day_step;
    logic div_avg_start;
    logic div_step;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic inc;
    logic acc;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic vol_nz;
    logic money_ge;
    logic money_ge2;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/dollar_bar_aggregator_unit.sv -----
// A tick without a deal is accepted in the idle state and closes no bar; a deal tick runs the
// day division, the multiply and accumulate steps, then one VWAP division for each bar it closes.
// Throughput: one tick per cycle without a deal while idle; no new tick is taken until a deal
// tick's bars have all gone out, and a bar waiting in the output register holds the sequencer.
// The 64-step bit-serial VWAP divider sets the pace.
// Reset: synchronous active-low rst_n clears all bar state; bar size resets to all ones.
module dollar_bar_aggregator_unit #(
  parameter int unsigned MAX_BARS_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_bid_price,
  input  logic [31:0] in_ask_price,
  input  logic [31:0] in_last_price,
  input  logic [31:0] in_deal_volume,
  input  logic [47:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_avg_price,
  output logic [47:0] out_start_ms,
  output logic [47:0] out_end_ms,
  output logic [47:0] out_gap_ms,
  output logic [15:0] out_tick_count,
  output logic [31:0] out_bid_high,
  output logic [31:0] out_bid_low,
  output logic [31:0] out_ask_high,
  output logic [31:0] out_ask_low,
  output logic [31:0] out_bar_id,
  output logic        out_is_last
);
  import dba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer.
  dba_ctrl #(.MAX_BARS_PER_TICK(MAX_BARS_PER_TICK)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  // Arithmetic and bar state.
  dba_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_bid_price(in_bid_price), .in_ask_price(in_ask_price),
    .in_last_price(in_last_price), .in_deal_volume(in_deal_volume),
    .in_time_ms(in_time_ms), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_avg_price(out_avg_price), .out_start_ms(out_start_ms),
    .out_end_ms(out_end_ms), .out_gap_ms(out_gap_ms),
    .out_tick_count(out_tick_count), .out_bid_high(out_bid_high),
    .out_bid_low(out_bid_low), .out_ask_high(out_ask_high),
    .out_ask_low(out_ask_low), .out_bar_id(out_bar_id),
    .out_is_last(out_is_last)
  );

endmodule

// ----- sv/dba_ctrl.sv -----
module dba_ctrl #(
  parameter int unsigned MAX_BARS_PER_TICK = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dba_pkg::sts_t sts,
  output dba_pkg::cmd_t cmd
);
  import dba_pkg::*;

  localparam int unsigned NW = $clog2(MAX_BARS_PER_TICK + 1);
  localparam int unsigned CW = $clog2(DivSteps);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic more;

  // Another bar follows this one only if money covers two sizes and the limit allows it.
  assign more = sts.money_ge2 && ((32'(n_r) + 32'd1) < MAX_BARS_PER_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        n_nxt    = '0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.vol_nz) state_nxt = S_DDIV;
        end
      end
      S_DDIV: begin
        cmd.day_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DaySteps - 1)) state_nxt = S_PREP;
      end
      S_ADIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DivSteps - 1)) state_nxt = S_EMIT;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_INC;
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.money_ge && (32'(n_r) < MAX_BARS_PER_TICK)) begin
          cmd.div_avg_start = 1'b1;
          state_nxt = S_ADIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = !more;
          n_nxt         = n_r + 1'b1;
          state_nxt     = S_CHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sv/dba_dp.sv -----
module dba_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [31:0]          in_bid_price,
  input  logic [31:0]          in_ask_price,
  input  logic [31:0]          in_last_price,
  input  logic [31:0]          in_deal_volume,
  input  logic [47:0]          in_time_ms,
  input  dba_pkg::cmd_t        cmd,
  output dba_pkg::sts_t        sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_avg_price,
  output logic [47:0]          out_start_ms,
  output logic [47:0]          out_end_ms,
  output logic [47:0]          out_gap_ms,
  output logic [15:0]          out_tick_count,
  output logic [31:0]          out_bid_high,
  output logic [31:0]          out_bid_low,
  output logic [31:0]          out_ask_high,
  output logic [31:0]          out_ask_low,
  output logic [31:0]          out_bar_id,
  output logic                 out_is_last
);
  import dba_pkg::*;

  logic [TimeW-1:0]  size_cfg_r;
  logic [31:0]       mpp_r;
  logic [31:0]       bid_i_r, ask_i_r, last_i_r, vol_i_r;
  logic [TimeW-1:0]  now_r;
  logic [MoneyW-1:0] money_r, pvs_r, pv_r, lo_r, hi_r, inc_r;
  logic [VsumW-1:0]  vsum_r;
  logic [31:0]       bid_hi_r, bid_lo_r, ask_hi_r, ask_lo_r;
  logic [15:0]       ticks_r;
  logic [TimeW-1:0]  start_r, prev_end_r, gap_r;
  logic [31:0]       day_r, id_r;
  logic [VsumW-1:0]  rem_r, dvs_r;
  logic [MoneyW-1:0] quot_r;
  logic              ov_r;
  logic [1:0]        dstep_r;
  logic [76:0]       day_acc_r;

  logic [TimeW-1:0]  size;
  logic [VsumW:0]    rem_sh;
  logic              q_bit;
  logic [31:0]       day_q, avg;
  logic [MoneyW:0]   inc_sum, pvs_sum, money_sum;
  logic [VsumW:0]    vsum_sum;
  logic [18:0]       day_x;
  logic [19:0]       day_m;
  logic [38:0]       day_pp;
  logic [57:0]       day_t1;
  logic [76:0]       day_term;

  assign size = (size_cfg_r == '0) ? TimeW'(1) : size_cfg_r;
  assign sts.vol_nz    = (in_deal_volume != '0);
  assign sts.money_ge  = (money_r >= MoneyW'(size));
  assign sts.money_ge2 = (money_r >= MoneyW'({size, 1'b0}));
  assign sts.out_free  = !out_valid || out_ready;

  // One restoring division step.
  assign rem_sh = {rem_r, quot_r[MoneyW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_r});
  assign avg    = (vsum_r == '0) ? last_i_r :
                  ((quot_r[MoneyW-1:32] != '0) ? '1 : quot_r[31:0]);

  // Day number by reciprocal multiplication of the time in 1024 ms units.
  // Each step multiplies one half of the time by one half of the reciprocal.
  assign day_x    = dstep_r[1] ? now_r[47:29] : now_r[28:10];
  assign day_m    = dstep_r[0] ? DayRecip[38:19] : {1'b0, DayRecip[18:0]};
  assign day_pp   = 39'(day_x) * 39'(day_m);
  assign day_t1   = dstep_r[0] ? {day_pp, 19'b0} : {19'b0, day_pp};
  assign day_term = dstep_r[1] ? {day_t1, 19'b0} : {19'b0, day_t1};
  assign day_q    = {10'b0, day_acc_r[76:55]};

  assign inc_sum   = {1'b0, hi_r[55:0], 8'b0} + {25'b0, lo_r[63:24]};
  assign pvs_sum   = {1'b0, pvs_r} + {1'b0, pv_r};
  assign money_sum = {1'b0, money_r} + {1'b0, inc_r};
  assign vsum_sum  = {1'b0, vsum_r} + {9'b0, vol_i_r};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= '1;
      mpp_r      <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgBarSize) size_cfg_r <= cfg_data[TimeW-1:0];
      else if (cfg_index == CfgMpp) mpp_r <= cfg_data[31:0];
    end
  end

  // Input latch, day, multiplier and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bid_i_r   <= in_bid_price;
      ask_i_r   <= in_ask_price;
      last_i_r  <= in_last_price;
      vol_i_r   <= in_deal_volume;
      now_r     <= in_time_ms;
      dstep_r   <= '0;
      day_acc_r <= '0;
    end else if (cmd.div_avg_start) begin
      rem_r  <= '0;
      quot_r <= pvs_r;
      dvs_r  <= vsum_r;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? VsumW'(rem_sh - {1'b0, dvs_r}) : rem_sh[VsumW-1:0];
      quot_r <= {quot_r[MoneyW-2:0], q_bit};
    end
    if (cmd.day_step) begin
      dstep_r   <= dstep_r + 2'd1;
      day_acc_r <= day_acc_r + day_term;
    end
    if (cmd.prep)   pv_r <= MoneyW'(vol_i_r) * MoneyW'(last_i_r);
    if (cmd.mul_lo) lo_r <= MoneyW'(pv_r[31:0]) * MoneyW'(mpp_r);
    if (cmd.mul_hi) hi_r <= MoneyW'(pv_r[63:32]) * MoneyW'(mpp_r);
    if (cmd.inc) begin
      ov_r  <= 1'b0;
      inc_r <= ((hi_r[63:56] != '0) || inc_sum[MoneyW]) ? '1 : inc_sum[MoneyW-1:0];
    end
  end

  // Bar state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      money_r <= '0; pvs_r <= '0; vsum_r <= '0;
      bid_hi_r <= '0; bid_lo_r <= '0; ask_hi_r <= '0; ask_lo_r <= '0;
      ticks_r <= '0; start_r <= '0; prev_end_r <= '0; gap_r <= '0;
      day_r <= '0; id_r <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_ask_price > ask_hi_r) ask_hi_r <= in_ask_price;
        else if (in_ask_price < ask_lo_r) ask_lo_r <= in_ask_price;
        if (in_bid_price > bid_hi_r) bid_hi_r <= in_bid_price;
        else if (in_bid_price < bid_lo_r) bid_lo_r <= in_bid_price;
      end
      if (cmd.prep) begin
        if (ticks_r == '0) begin
          day_r   <= day_q;
          start_r <= now_r;
          gap_r   <= (now_r >= prev_end_r) ? now_r - prev_end_r : '0;
          bid_hi_r <= bid_i_r; bid_lo_r <= bid_i_r;
          ask_hi_r <= ask_i_r; ask_lo_r <= ask_i_r;
          ticks_r <= 16'd1;
        end else if (day_q != day_r) begin
          // A deal on a new day drops the partial bar.
          day_r   <= day_q;
          start_r <= now_r;
          gap_r   <= '0;
          money_r <= '0; pvs_r <= '0; vsum_r <= '0;
          bid_hi_r <= bid_i_r; bid_lo_r <= bid_i_r;
          ask_hi_r <= ask_i_r; ask_lo_r <= ask_i_r;
          ticks_r <= 16'd1;
        end else if (ticks_r != '1) begin
          ticks_r <= ticks_r + 16'd1;
        end
      end
      if (cmd.acc) begin
        pvs_r   <= pvs_sum[MoneyW] ? '1 : pvs_sum[MoneyW-1:0];
        money_r <= money_sum[MoneyW] ? '1 : money_sum[MoneyW-1:0];
        vsum_r  <= vsum_sum[VsumW] ? '1 : vsum_sum[VsumW-1:0];
      end
      if (cmd.emit) begin
        id_r       <= id_r + 32'd1;
        pvs_r      <= '0;
        vsum_r     <= '0;
        ticks_r    <= '0;
        gap_r      <= '0;
        start_r    <= now_r;
        prev_end_r <= now_r;
        money_r    <= money_r - MoneyW'(size);
      end
    end
  end

  // Output register beat.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_avg_price  <= avg;
      out_start_ms   <= start_r;
      out_end_ms     <= now_r;
      out_gap_ms     <= gap_r;
      out_tick_count <= ticks_r;
      out_bid_high   <= bid_hi_r;
      out_bid_low    <= bid_lo_r;
      out_ask_high   <= ask_hi_r;
      out_ask_low    <= ask_lo_r;
      out_bar_id     <= id_r;
      out_is_last    <= cmd.emit_last || ov_r;
    end
  end

endmodule
